[src/hirs_pkg.sv]
// shared types, constants and match patterns for the http image response scanner
package hirs_pkg;

    localparam int MAX_MESSAGE_BYTES = 65536;
    localparam int POS_W             = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int WINDOW_LEN        = 21;
    localparam int LEN_PAT_LEN       = 17;
    localparam int END_PAT_LEN       = 4;
    localparam int LEN_W             = 31;
    localparam int DROP_W            = 32;
    localparam logic [LEN_W+3:0] LENGTH_LIMIT = 35'd2147483647;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        t_byte data_byte;
        logic  last_byte;
    } t_in_word;

    typedef struct packed {
        logic              found_image;
        logic [DROP_W-1:0] drop_bytes;
    } t_result;

    localparam t_byte TYPE_PATTERN [WINDOW_LEN] = '{
        8'h0d, 8'h0a, "C", "o", "n", "t", "e", "n", "t", "-", "T", "y", "p", "e", ":",
        " ", "i", "m", "a", "g", "e"
    };

    localparam t_byte LENGTH_PATTERN [LEN_PAT_LEN] = '{
        8'h0d, 8'h0a, "C", "o", "n", "t", "e", "n", "t", "-", "L", "e", "n", "g", "t",
        "h", ":"
    };

    localparam t_byte END_PATTERN [END_PAT_LEN] = '{8'h0d, 8'h0a, 8'h0d, 8'h0a};

endpackage

[src/hirs_in_reg.sv]
// input register holding one accepted word until the scanner takes it
module hirs_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hirs_pkg::t_in_word i_word,
    output logic               o_stall,
    input  logic               i_take,
    output logic               o_valid,
    output hirs_pkg::t_in_word o_word
);

    logic               r_valid;
    logic               n_valid;
    hirs_pkg::t_in_word r_word;
    logic               load;

    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

[src/hirs_scan.sv]
// byte window, pattern matchers, length accumulator and per-response state
module hirs_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  hirs_pkg::t_in_word i_word,
    output logic               o_res_valid,
    output hirs_pkg::t_result  o_result
);

    hirs_pkg::t_byte                 r_window [hirs_pkg::WINDOW_LEN];
    hirs_pkg::t_byte                 n_window [hirs_pkg::WINDOW_LEN];
    logic                            r_type_seen,  n_type_seen;
    logic [1:0]                      r_phase,      n_phase;
    logic [hirs_pkg::LEN_W-1:0]      r_value,      n_value;
    logic                            r_overflow,   n_overflow;
    logic                            r_has_digit,  n_has_digit;
    logic                            r_body_found, n_body_found;
    logic [hirs_pkg::POS_W-1:0]      r_body_off,   n_body_off;
    logic [hirs_pkg::POS_W-1:0]      r_pos,        n_pos;
    logic                            r_ended,      n_ended;

    logic                            is_digit;
    logic [hirs_pkg::LEN_W+3:0]      acc;
    logic                            type_hit;
    logic                            len_hit;
    logic                            end_hit;
    logic                            found;
    hirs_pkg::t_byte                 b;

    assign b        = i_word.data_byte;
    assign is_digit = (b >= "0") && (b <= "9");
    assign acc      = ({4'b0000, r_value} << 3) + ({4'b0000, r_value} << 1)
                    + {27'd0, b - 8'h30};

    always_comb begin
        n_window     = r_window;
        n_type_seen  = r_type_seen;
        n_phase      = r_phase;
        n_value      = r_value;
        n_overflow   = r_overflow;
        n_has_digit  = r_has_digit;
        n_body_found = r_body_found;
        n_body_off   = r_body_off;
        n_pos        = r_pos;
        n_ended      = r_ended;
        type_hit     = 1'b0;
        len_hit      = 1'b0;
        end_hit      = 1'b0;
        if (!r_ended && (r_pos < hirs_pkg::POS_W'(hirs_pkg::MAX_MESSAGE_BYTES))) begin
            if (b == 8'h00) begin
                n_ended = 1'b1;
                if (r_phase == hirs_pkg::PH_SKIP || r_phase == hirs_pkg::PH_DIGITS) begin
                    n_phase = hirs_pkg::PH_DONE;
                end
            end else begin
                n_pos = r_pos + 1'b1;
                if (r_phase == hirs_pkg::PH_SKIP) begin
                    n_phase = hirs_pkg::PH_DIGITS;
                end else if (r_phase == hirs_pkg::PH_DIGITS) begin
                    if (is_digit) begin
                        n_has_digit = 1'b1;
                        if (!r_overflow) begin
                            if (acc > hirs_pkg::LENGTH_LIMIT) begin
                                n_overflow = 1'b1;
                            end else begin
                                n_value = acc[hirs_pkg::LEN_W-1:0];
                            end
                        end
                    end else begin
                        n_phase = hirs_pkg::PH_DONE;
                    end
                end
                for (int i = 0; i < hirs_pkg::WINDOW_LEN - 1; i++) begin
                    n_window[i] = r_window[i+1];
                end
                n_window[hirs_pkg::WINDOW_LEN-1] = b;
                type_hit = 1'b1;
                for (int i = 0; i < hirs_pkg::WINDOW_LEN; i++) begin
                    if (n_window[i] != hirs_pkg::TYPE_PATTERN[i]) begin
                        type_hit = 1'b0;
                    end
                end
                len_hit = 1'b1;
                for (int i = 0; i < hirs_pkg::LEN_PAT_LEN; i++) begin
                    if (n_window[hirs_pkg::WINDOW_LEN - hirs_pkg::LEN_PAT_LEN + i]
                        != hirs_pkg::LENGTH_PATTERN[i]) begin
                        len_hit = 1'b0;
                    end
                end
                end_hit = 1'b1;
                for (int i = 0; i < hirs_pkg::END_PAT_LEN; i++) begin
                    if (n_window[hirs_pkg::WINDOW_LEN - hirs_pkg::END_PAT_LEN + i]
                        != hirs_pkg::END_PATTERN[i]) begin
                        end_hit = 1'b0;
                    end
                end
                if (type_hit) begin
                    n_type_seen = 1'b1;
                end
                if (n_phase == hirs_pkg::PH_IDLE && len_hit) begin
                    n_phase = hirs_pkg::PH_SKIP;
                end
                if (!r_body_found && end_hit) begin
                    n_body_found = 1'b1;
                    n_body_off   = n_pos;
                end
            end
        end
    end

    assign found = n_type_seen && n_phase[1] && n_has_digit && !n_overflow && n_body_found;

    assign o_res_valid          = i_go && i_word.last_byte;
    assign o_result.found_image = found;
    assign o_result.drop_bytes  = found
        ? (hirs_pkg::DROP_W'(n_body_off) + hirs_pkg::DROP_W'(n_value))
        : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_word.last_byte)) begin
            for (int i = 0; i < hirs_pkg::WINDOW_LEN; i++) begin
                r_window[i] <= 8'h00;
            end
            r_type_seen  <= 1'b0;
            r_phase      <= hirs_pkg::PH_IDLE;
            r_value      <= '0;
            r_overflow   <= 1'b0;
            r_has_digit  <= 1'b0;
            r_body_found <= 1'b0;
            r_body_off   <= '0;
            r_pos        <= '0;
            r_ended      <= 1'b0;
        end else if (i_go) begin
            r_window     <= n_window;
            r_type_seen  <= n_type_seen;
            r_phase      <= n_phase;
            r_value      <= n_value;
            r_overflow   <= n_overflow;
            r_has_digit  <= n_has_digit;
            r_body_found <= n_body_found;
            r_body_off   <= n_body_off;
            r_pos        <= n_pos;
            r_ended      <= n_ended;
        end
    end

endmodule

[src/hirs_out_reg.sv]
// result register holding one finished word until the receiver takes it
module hirs_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  hirs_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output hirs_pkg::t_result o_result
);

    logic              r_valid;
    logic              n_valid;
    hirs_pkg::t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[src/http_image_response_scanner.sv]
// top level of the http image response scanner
// Takes one response byte per cycle and sustains one byte every cycle unless input stalls.
// Each byte is held in an input register until scanned, then a single pass of window compares
// and a decimal multiply-by-ten accumulate updates the scan state; the byte flagged last also
// loads its result into the result register, which presents it. Input stalls only while a
// result waits in the result register and the next byte to scan is a last byte. After each
// result all scan state returns to its reset value for the next response.
module http_image_response_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_found_image,
    output logic [31:0] o_drop_bytes
);

    hirs_pkg::t_in_word in_word;
    hirs_pkg::t_in_word held_word;
    logic               held_valid;
    logic               out_free;
    logic               go;
    logic               res_valid;
    hirs_pkg::t_result  res;
    hirs_pkg::t_result  out_res;

    assign in_word.data_byte = i_data_byte;
    assign in_word.last_byte = i_last_byte;

    assign go = held_valid && (!held_word.last_byte || out_free);

    hirs_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_word  (in_word),
        .o_stall (o_in_stall),
        .i_take  (go),
        .o_valid (held_valid),
        .o_word  (held_word)
    );

    hirs_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_word      (held_word),
        .o_res_valid (res_valid),
        .o_result    (res)
    );

    hirs_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (res),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_res)
    );

    assign o_found_image = out_res.found_image;
    assign o_drop_bytes  = out_res.drop_bytes;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && held_word.last_byte) |=> o_out_valid)
        else $error("last byte scanned without a result word");

    a_result_not_overwritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !res_valid)
        else $error("result register overwritten while stalled");

    a_held_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (held_valid && !go) |=> held_valid)
        else $error("held byte lost without being scanned");

    a_drop_matches_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_found_image == (o_drop_bytes != 32'd0)))
        else $error("drop count disagrees with found flag");

endmodule
